// File: sv/wfu_pkg.sv
// Shared types and constants for the WebSocket frame unmasker.
`timescale 1ns / 1ps
`default_nettype none

package wfu_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       valid;
		logic       last;
		logic       err;
	} op_t;

endpackage

`default_nettype wire

// File: sv/wfu_front.sv
// Front end: frame header parser that classifies stream bytes into result ops.
`timescale 1ns / 1ps
`default_nettype none

module wfu_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_fire,
	input  wire  [7:0]        rx_byte,
	output logic              push,
	output wfu_pkg::op_t      op
);

	localparam logic [2:0] PH_HDR  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [2:0]  phase_q;
	logic [15:0] remaining_q;
	logic [31:0] mask_key_q;
	logic [1:0]  hdr_idx_q;
	logic [1:0]  mask_idx_q;

	logic [6:0]  code;
	logic [7:0]  key_byte;

	assign code = rx_byte[6:0];

	always_comb begin
		case (mask_idx_q)
			2'd0: key_byte = mask_key_q[31:24];
			2'd1: key_byte = mask_key_q[23:16];
			2'd2: key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	always_comb begin
		push     = 1'b0;
		op.data  = 8'd0;
		op.key   = 8'd0;
		op.valid = 1'b0;
		op.last  = 1'b1;
		op.err   = 1'b0;
		case (phase_q)
			PH_LEN: begin
				if (in_fire && code == wfu_pkg::LEN_EXT64) begin
					push   = 1'b1;
					op.err = 1'b1;
				end
			end
			PH_MASK: begin
				if (in_fire && hdr_idx_q == 2'd3 && remaining_q == 16'd0) begin
					push = 1'b1;
				end
			end
			PH_DATA: begin
				push     = in_fire;
				op.data  = rx_byte;
				op.key   = key_byte;
				op.valid = 1'b1;
				op.last  = (remaining_q == 16'd1);
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			remaining_q <= 16'd0;
			mask_key_q  <= 32'd0;
			hdr_idx_q   <= 2'd0;
			mask_idx_q  <= 2'd0;
		end else if (in_fire) begin
			case (phase_q)
				PH_LEN: begin
					hdr_idx_q <= 2'd0;
					if (code == wfu_pkg::LEN_EXT64) begin
						phase_q <= PH_HDR;
					end else if (code == wfu_pkg::LEN_EXT16) begin
						remaining_q <= 16'd0;
						phase_q     <= PH_EXT;
					end else begin
						remaining_q <= {9'd0, code};
						phase_q     <= PH_MASK;
					end
				end
				PH_EXT: begin
					remaining_q <= {remaining_q[7:0], rx_byte};
					if (hdr_idx_q[0]) begin
						hdr_idx_q <= 2'd0;
						phase_q   <= PH_MASK;
					end else begin
						hdr_idx_q <= 2'd1;
					end
				end
				PH_MASK: begin
					case (hdr_idx_q)
						2'd0: mask_key_q[31:24] <= rx_byte;
						2'd1: mask_key_q[23:16] <= rx_byte;
						2'd2: mask_key_q[15:8]  <= rx_byte;
						default: mask_key_q[7:0] <= rx_byte;
					endcase
					if (hdr_idx_q == 2'd3) begin
						hdr_idx_q  <= 2'd0;
						mask_idx_q <= 2'd0;
						phase_q    <= (remaining_q == 16'd0) ? PH_HDR : PH_DATA;
					end else begin
						hdr_idx_q <= hdr_idx_q + 2'd1;
					end
				end
				PH_DATA: begin
					mask_idx_q  <= mask_idx_q + 2'd1;
					remaining_q <= remaining_q - 16'd1;
					if (remaining_q == 16'd1) begin
						phase_q <= PH_HDR;
					end
				end
				default: begin
					phase_q <= PH_LEN;
				end
			endcase
		end
	end

	a_push_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_fire) else $error("op pushed without an accepted item");
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && op.err |-> op.last && !op.valid) else $error("error op not marked last");

endmodule

`default_nettype wire

// File: sv/wfu_queue.sv
// Short op queue between the header parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module wfu_queue #(
	parameter int DEPTH = wfu_pkg::QUEUE_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wfu_pkg::op_t      push_op,
	output logic              full,
	input  wire               pop,
	output wfu_pkg::op_t      pop_op,
	output logic              not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	wfu_pkg::op_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_op    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: sv/wfu_back.sv
// Back end: unmasks queued ops into the registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module wfu_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               not_empty,
	input  wfu_pkg::op_t      op,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  wire               m_axis_tready,
	output logic [7:0]        m_axis_tdata,
	output logic              m_axis_tlast,
	output logic [1:0]        m_axis_tuser
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic [1:0] user_q;

	assign pop           = not_empty && (!valid_q || m_axis_tready);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= op.data ^ op.key;
			last_q <= op.last;
			user_q <= {op.err, op.valid};
		end
	end

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid) else $error("popped op not presented");

endmodule

`default_nettype wire

// File: sv/websocket_frame_unmasker.sv
// Top level of the WebSocket client frame unmasker.
//
// Input: one received stream byte per item on s_axis (tdata = rx_byte).
// Each frame is a header byte (ignored), a length byte (code 126 adds a
// 16-bit big-endian length), four mask-key bytes and the payload.
// Output: one item per payload byte on m_axis, tdata = unmasked byte,
// tlast marks the last item of a frame, tuser = {length_error, data_valid}.
// A zero-length frame gives one item with data_valid low and tlast high.
// Length code 127 gives one item with length_error and tlast high, and the
// parser then waits for the next frame's header byte.
// Throughput: one byte per cycle while the queue is not full; the parser steps once per byte.
// An item that produces a result is written to the queue at the accepting
// edge and reaches m_axis through the output register once that is free.
// Reset clears the parser to wait for a header byte and empties the queue.
// When the receiver stalls, the output register holds, the queue fills and
// s_axis_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_unmasker #(
	parameter int QUEUE_DEPTH = wfu_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser    // [0] data_valid, [1] length_error
);

	logic         in_fire;
	logic         push;
	logic         full;
	logic         pop;
	logic         not_empty;
	wfu_pkg::op_t push_op;
	wfu_pkg::op_t pop_op;

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	wfu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (s_axis_tdata),
		.push    (push),
		.op      (push_op)
	);

	wfu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (full),
		.pop       (pop),
		.pop_op    (pop_op),
		.not_empty (not_empty)
	);

	wfu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.not_empty     (not_empty),
		.op            (pop_op),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire
